FILE: hw/rtl/tfe_pkg.sv
package tfe_pkg;

  typedef enum logic [1:0] {
    AXIS_X = 2'd0,
    AXIS_Y = 2'd1,
    AXIS_Z = 2'd2
  } axis_t;

  // square root of |c|^2 * 2^16, one result bit per stage
  localparam int LW   = 24;
  localparam int RADW = 2 * LW;
  localparam int SRW  = LW + 2;

  localparam int OCT_QW = 10;
  localparam int OCT_DW = 18;
  localparam int OCT_RW = OCT_DW + OCT_QW;
  localparam int COS_QW = 8;

  localparam logic [OCT_QW-1:0] OCT_CENTER = 10'd511;
  localparam logic [COS_QW-1:0] COS_NONE   = 8'd128;
  localparam logic [COS_QW-1:0] COS_MIN    = 8'd0;
  localparam logic [COS_QW-1:0] COS_MAX    = 8'd255;

  // stage map
  localparam int ST_ABS  = 1;
  localparam int ST_SEL  = 2;
  localparam int ST_MUL  = 3;
  localparam int ST_SUM  = 4;
  localparam int ST_EMUL = 5;
  localparam int ST_E    = 6;
  localparam int ST_E10A = 7;
  localparam int ST_E10B = 8;
  localparam int OD0     = 5;
  localparam int SQ0     = 5;
  localparam int ST_X    = SQ0 + LW;
  localparam int ST_P    = ST_X + 1;
  localparam int ST_N    = ST_X + 2;
  localparam int CD0     = ST_X + 3;
  localparam int ST_PACK = CD0 + COS_QW;
  localparam int DEPTH   = ST_PACK + 1;

endpackage

FILE: hw/rtl/tangent_frame_encoder.sv
// every accepted start beat gives one out_valid beat, in order
// throughput: one vertex per cycle; busy stays low, results never wait
// depth is set by the square root of the reference length, one bit per stage,
// followed by the bit-serial cosine divider
// reset (rst_n low at a clock edge) clears the valid bits; data stages are not reset
module tangent_frame_encoder
  import tfe_pkg::*;
#(
  parameter int FRAC_BITS = 14
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [15:0] in_normal_x,
  input  logic [15:0] in_normal_y,
  input  logic [15:0] in_normal_z,
  input  logic [15:0] in_tangent_x,
  input  logic [15:0] in_tangent_y,
  input  logic [15:0] in_tangent_z,
  input  logic        in_binormal_flip,
  output logic        out_valid,
  output logic [31:0] out_packed_frame
);

  localparam int SHIFT = 2 * FRAC_BITS - 8;
  localparam int DW    = 35;
  localparam int EW    = 51;
  localparam int CMPW  = EW + 14;
  localparam int XMAX  = (LW + FRAC_BITS > 40) ? LW + FRAC_BITS : 40;
  localparam int XW    = XMAX + 2;
  localparam int PW    = XW + 8;
  localparam int NW    = PW - FRAC_BITS - 1;

  typedef struct packed {
    logic signed [15:0]     nx;
    logic signed [15:0]     ny;
    logic signed [15:0]     nz;
    logic signed [15:0]     tx;
    logic signed [15:0]     ty;
    logic signed [15:0]     tz;
    logic                   flip;
    logic [16:0]            mag_nx;
    logic [16:0]            mag_ny;
    logic [16:0]            mag_nz;
    logic [16:0]            mag_tx;
    logic [16:0]            mag_ty;
    logic [16:0]            mag_tz;
    logic [16:0]            l1;
    logic                   l1_zero;
    axis_t                  axis;
    logic signed [16:0]     cx;
    logic signed [16:0]     cy;
    logic signed [16:0]     cz;
    logic signed [15:0]     na;
    logic signed [15:0]     ta;
    logic [OCT_DW-1:0]      num_x;
    logic [OCT_DW-1:0]      num_y;
    logic [31:0]            sq_x;
    logic [31:0]            sq_y;
    logic [31:0]            sq_z;
    logic signed [32:0]     dp_x;
    logic signed [32:0]     dp_y;
    logic signed [32:0]     dp_z;
    logic signed [31:0]     tn_x;
    logic signed [31:0]     tn_y;
    logic signed [31:0]     tn_z;
    logic [31:0]            nn_x;
    logic [31:0]            nn_y;
    logic [31:0]            nn_z;
    logic                   q_zero;
    logic signed [DW-1:0]   d_sum;
    logic signed [33:0]     tn_sum;
    logic [31:0]            nn_sum;
    logic [OCT_RW-1:0]      ox_rem;
    logic [OCT_RW-1:0]      oy_rem;
    logic [OCT_DW-1:0]      oct_div;
    logic [OCT_QW-1:0]      ox_q;
    logic [OCT_QW-1:0]      oy_q;
    logic signed [49:0]     e1;
    logic signed [49:0]     e2;
    logic signed [EW-1:0]   e_val;
    logic signed [CMPW-1:0] e_part;
    logic signed [CMPW-1:0] e10;
    logic [RADW-1:0]        rad;
    logic [SRW-1:0]         s_rem;
    logic [LW-1:0]          root;
    logic signed [XW-1:0]   x_val;
    logic signed [CMPW-1:0] thr;
    logic signed [PW-1:0]   p_val;
    logic                   x_pos;
    logic                   th;
    logic [NW-1:0]          c_rem;
    logic                   sat;
    logic [COS_QW-1:0]      cos_q;
    logic [31:0]            word;
  } stage_t;

  stage_t           pipe_r   [DEPTH];
  stage_t           pipe_nxt [DEPTH];
  logic [DEPTH-1:0] vld_r;
  logic [DEPTH-1:0] vld_nxt;
  logic             accept;

  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign vld_nxt = {vld_r[DEPTH-2:0], accept};

  always_comb begin
    pipe_nxt[0]      = '0;
    pipe_nxt[0].nx   = $signed(in_normal_x);
    pipe_nxt[0].ny   = $signed(in_normal_y);
    pipe_nxt[0].nz   = $signed(in_normal_z);
    pipe_nxt[0].tx   = $signed(in_tangent_x);
    pipe_nxt[0].ty   = $signed(in_tangent_y);
    pipe_nxt[0].tz   = $signed(in_tangent_z);
    pipe_nxt[0].flip = in_binormal_flip;
  end

  for (genvar g = 1; g < DEPTH; g++) begin : g_stage
    localparam bit IN_OCT = (g >= OD0) && (g < OD0 + OCT_QW);
    localparam bit IN_SQ  = (g >= SQ0) && (g < SQ0 + LW);
    localparam bit IN_COS = (g >= CD0) && (g < CD0 + COS_QW);
    localparam int OK     = IN_OCT ? OCT_QW - 1 - (g - OD0) : 0;
    localparam int CK     = IN_COS ? COS_QW - 1 - (g - CD0) : 0;

    always_comb begin
      stage_t                 p;
      stage_t                 s;
      logic [OCT_RW-1:0]      o_dv;
      logic [SRW+1:0]         s_tmp;
      logic [SRW+1:0]         s_trial;
      logic [NW-1:0]          c_dv;
      logic signed [CMPW-1:0] e_ext;
      logic signed [XW-1:0]   d_ext;
      logic signed [PW-1:0]   x_ext;
      logic [COS_QW-1:0]      cos_code;
      logic [OCT_QW-1:0]      code_x;
      logic [OCT_QW-1:0]      code_y;

      p        = pipe_r[g-1];
      s        = p;
      o_dv     = OCT_RW'(p.oct_div) << OK;
      s_tmp    = {p.s_rem, p.rad[RADW-1 -: 2]};
      s_trial  = (SRW+2)'({p.root, 2'b01});
      c_dv     = NW'(p.root) << CK;
      e_ext    = $signed({{(CMPW-EW){p.e_val[EW-1]}}, p.e_val});
      d_ext    = $signed({{(XW-DW){p.d_sum[DW-1]}}, p.d_sum});
      x_ext    = $signed({{(PW-XW){p.x_val[XW-1]}}, p.x_val});
      cos_code = COS_MIN;
      code_x   = OCT_CENTER;
      code_y   = OCT_CENTER;

      if (g == ST_ABS) begin
        s.mag_nx = p.nx[15] ? 17'(-$signed({p.nx[15], p.nx})) : {1'b0, p.nx};
        s.mag_ny = p.ny[15] ? 17'(-$signed({p.ny[15], p.ny})) : {1'b0, p.ny};
        s.mag_nz = p.nz[15] ? 17'(-$signed({p.nz[15], p.nz})) : {1'b0, p.nz};
        s.mag_tx = p.tx[15] ? 17'(-$signed({p.tx[15], p.tx})) : {1'b0, p.tx};
        s.mag_ty = p.ty[15] ? 17'(-$signed({p.ty[15], p.ty})) : {1'b0, p.ty};
        s.mag_tz = p.tz[15] ? 17'(-$signed({p.tz[15], p.tz})) : {1'b0, p.tz};
      end

      if (g == ST_SEL) begin
        s.l1      = p.mag_nx + p.mag_ny + p.mag_nz;
        s.l1_zero = (p.nx == 16'sd0) && (p.ny == 16'sd0) && (p.nz == 16'sd0);
        // c = n x e for the largest tangent axis, ties to the lower axis
        priority if (p.mag_tx >= p.mag_ty && p.mag_tx >= p.mag_tz) begin
          s.axis = AXIS_X;
          s.cx   = 17'sd0;
          s.cy   = $signed({p.nz[15], p.nz});
          s.cz   = -$signed({p.ny[15], p.ny});
          s.na   = p.nx;
          s.ta   = p.tx;
        end else if (p.mag_ty >= p.mag_tz) begin
          s.axis = AXIS_Y;
          s.cx   = -$signed({p.nz[15], p.nz});
          s.cy   = 17'sd0;
          s.cz   = $signed({p.nx[15], p.nx});
          s.na   = p.ny;
          s.ta   = p.ty;
        end else begin
          s.axis = AXIS_Z;
          s.cx   = $signed({p.ny[15], p.ny});
          s.cy   = -$signed({p.nx[15], p.nx});
          s.cz   = 17'sd0;
          s.na   = p.nz;
          s.ta   = p.tz;
        end
      end

      if (g == ST_MUL) begin
        // octahedral numerators, lower hemisphere folded
        if (!p.nz[15]) begin
          s.num_x = {{2{p.nx[15]}}, p.nx} + {1'b0, p.l1};
          s.num_y = {{2{p.ny[15]}}, p.ny} + {1'b0, p.l1};
        end else begin
          s.num_x = p.nx[15] ? {1'b0, p.mag_ny} : {p.l1, 1'b0} - {1'b0, p.mag_ny};
          s.num_y = p.ny[15] ? {1'b0, p.mag_nx} : {p.l1, 1'b0} - {1'b0, p.mag_nx};
        end
        s.sq_x   = 32'(p.cx * p.cx);
        s.sq_y   = 32'(p.cy * p.cy);
        s.sq_z   = 32'(p.cz * p.cz);
        s.dp_x   = p.tx * p.cx;
        s.dp_y   = p.ty * p.cy;
        s.dp_z   = p.tz * p.cz;
        s.tn_x   = p.tx * p.nx;
        s.tn_y   = p.ty * p.ny;
        s.tn_z   = p.tz * p.nz;
        s.nn_x   = 32'(p.nx * p.nx);
        s.nn_y   = 32'(p.ny * p.ny);
        s.nn_z   = 32'(p.nz * p.nz);
        s.q_zero = (p.cx == 17'sd0) && (p.cy == 17'sd0) && (p.cz == 17'sd0);
      end

      if (g == ST_SUM) begin
        s.d_sum   = DW'(p.dp_x) + DW'(p.dp_y) + DW'(p.dp_z);
        s.tn_sum  = 34'(p.tn_x) + 34'(p.tn_y) + 34'(p.tn_z);
        s.nn_sum  = p.nn_x + p.nn_y + p.nn_z;
        s.ox_rem  = {p.num_x, {OCT_QW{1'b0}}} - OCT_RW'(p.num_x);
        s.oy_rem  = {p.num_y, {OCT_QW{1'b0}}} - OCT_RW'(p.num_y);
        s.oct_div = {p.l1, 1'b0};
        s.ox_q    = '0;
        s.oy_q    = '0;
        s.rad     = {p.sq_x + p.sq_y + p.sq_z, {(RADW-32){1'b0}}};
        s.s_rem   = '0;
        s.root    = '0;
      end

      if (IN_OCT) begin
        if (p.ox_rem >= o_dv) begin
          s.ox_rem = p.ox_rem - o_dv;
          s.ox_q   = {p.ox_q[OCT_QW-2:0], 1'b1};
        end else begin
          s.ox_q   = {p.ox_q[OCT_QW-2:0], 1'b0};
        end
        if (p.oy_rem >= o_dv) begin
          s.oy_rem = p.oy_rem - o_dv;
          s.oy_q   = {p.oy_q[OCT_QW-2:0], 1'b1};
        end else begin
          s.oy_q   = {p.oy_q[OCT_QW-2:0], 1'b0};
        end
      end

      // E = t . (n x c) = (t.n) n_axis - t_axis |n|^2
      if (g == ST_EMUL) begin
        s.e1 = p.tn_sum * p.na;
        s.e2 = $signed({1'b0, p.nn_sum}) * p.ta;
      end

      if (g == ST_E) begin
        s.e_val = EW'(p.e1) - EW'(p.e2);
      end

      // times 10000 as shifted adds
      if (g == ST_E10A) begin
        s.e_part = (e_ext <<< 13) + (e_ext <<< 10) + (e_ext <<< 9);
      end

      if (g == ST_E10B) begin
        s.e10 = p.e_part + (e_ext <<< 8) + (e_ext <<< 4);
      end

      if (IN_SQ) begin
        s.rad = p.rad << 2;
        if (s_tmp >= s_trial) begin
          s.s_rem = SRW'(s_tmp - s_trial);
          s.root  = {p.root[LW-2:0], 1'b1};
        end else begin
          s.s_rem = s_tmp[SRW-1:0];
          s.root  = {p.root[LW-2:0], 1'b0};
        end
      end

      if (g == ST_X) begin
        s.x_val = (d_ext <<< 8) + $signed(XW'(p.root) << FRAC_BITS);
        s.thr   = $signed(CMPW'(p.root) << SHIFT);
      end

      if (g == ST_P) begin
        s.p_val = (x_ext <<< 8) - x_ext;
        s.x_pos = !p.x_val[XW-1] && (p.x_val != '0);
        s.th    = !p.q_zero && !p.e_val[EW-1] && (p.e_val != '0) && (p.e10 > p.thr);
      end

      if (g == ST_N) begin
        s.c_rem = p.p_val[PW-1:FRAC_BITS+1];
        s.sat   = p.p_val[PW-1:FRAC_BITS+1] >= (NW'(p.root) << COS_QW);
        s.cos_q = '0;
      end

      if (IN_COS) begin
        if (p.c_rem >= c_dv) begin
          s.c_rem = p.c_rem - c_dv;
          s.cos_q = {p.cos_q[COS_QW-2:0], 1'b1};
        end else begin
          s.cos_q = {p.cos_q[COS_QW-2:0], 1'b0};
        end
      end

      if (g == ST_PACK) begin
        priority if (p.q_zero) begin
          cos_code = COS_NONE;
        end else if (!p.x_pos) begin
          cos_code = COS_MIN;
        end else if (p.sat) begin
          cos_code = COS_MAX;
        end else begin
          cos_code = p.cos_q;
        end
        if (!p.l1_zero) begin
          code_x = p.ox_q;
          code_y = p.oy_q;
        end
        s.word = {p.flip, p.th, p.axis, cos_code, code_y, code_x};
      end

      pipe_nxt[g] = s;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < DEPTH; i++) begin
      pipe_r[i] <= pipe_nxt[i];
    end
  end

  assign out_valid        = vld_r[DEPTH-1];
  assign out_packed_frame = pipe_r[DEPTH-1].word;

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##DEPTH out_valid)
    else $error("accepted vertex did not come out after the pipeline depth");

  a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(accept, DEPTH))
    else $error("result without a matching start beat");

  a_zero_normal: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_PACK-1] && pipe_r[ST_PACK-1].l1_zero |-> pipe_r[ST_PACK-1].q_zero)
    else $error("zero normal with nonzero reference cross product");

  a_zero_cross: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_PACK-1] && pipe_r[ST_PACK-1].q_zero |=>
      !out_packed_frame[30] && out_packed_frame[27:20] == COS_NONE)
    else $error("zero cross product must give neutral cosine and no handedness");

  a_axis_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_packed_frame[29:28] == AXIS_X || out_packed_frame[29:28] == AXIS_Y ||
                   out_packed_frame[29:28] == AXIS_Z))
    else $error("axis field holds an unused code");

endmodule

FILE: tb/tangent_frame_encoder_tb.sv
module tangent_frame_encoder_tb
  import tfe_pkg::*;
();

  localparam int FRAC = 14;

  class frame_scoreboard;
    logic [31:0] frames_due[$];
    int fails;
    int beats_in;
    int beats_out;

    static function automatic longint unsigned root_floor(longint unsigned v);
      longint unsigned r;
      longint unsigned t;
      r = 0;
      for (int b = 23; b >= 0; b--) begin
        t = r | (64'd1 << b);
        if (t * t <= v) r = t;
      end
      return r;
    endfunction

    static function automatic longint oct_quant(longint num, longint l1);
      longint c;
      c = (1023 * num) / (2 * l1);
      if (c < 0) c = 0;
      if (c > 1023) c = 1023;
      return c;
    endfunction

    static function automatic logic [31:0] encode_frame(
      logic [15:0] nxr, logic [15:0] nyr, logic [15:0] nzr,
      logic [15:0] txr, logic [15:0] tyr, logic [15:0] tzr, logic flip);
      longint nx, ny, nz, tx, ty, tz, l1, ax, ay, az, cx, cy, cz;
      longint l, d, num, den, bx, by, bz, e, thr, c, s;
      longint unsigned q;
      logic [9:0] code_x, code_y;
      logic [7:0] cosc;
      axis_t axis;
      logic th;
      nx = longint'($signed(nxr)); ny = longint'($signed(nyr));
      nz = longint'($signed(nzr)); tx = longint'($signed(txr));
      ty = longint'($signed(tyr)); tz = longint'($signed(tzr));
      s = longint'(1) << FRAC;
      l1 = (nx < 0 ? -nx : nx) + (ny < 0 ? -ny : ny) + (nz < 0 ? -nz : nz);
      ax = tx < 0 ? -tx : tx;
      ay = ty < 0 ? -ty : ty;
      az = tz < 0 ? -tz : tz;
      if (l1 == 0) begin
        code_x = OCT_CENTER;
        code_y = OCT_CENTER;
      end else if (nz >= 0) begin
        code_x = 10'(oct_quant(nx + l1, l1));
        code_y = 10'(oct_quant(ny + l1, l1));
      end else begin
        // lower hemisphere folds over the diagonals
        code_x = 10'(oct_quant(nx >= 0 ? 2 * l1 - (ny < 0 ? -ny : ny)
                                        : (ny < 0 ? -ny : ny), l1));
        code_y = 10'(oct_quant(ny >= 0 ? 2 * l1 - (nx < 0 ? -nx : nx)
                                        : (nx < 0 ? -nx : nx), l1));
      end
      if (ax >= ay && ax >= az) begin
        axis = AXIS_X; cx = 0; cy = nz; cz = -ny;
      end else if (ay >= az) begin
        axis = AXIS_Y; cx = -nz; cy = 0; cz = nx;
      end else begin
        axis = AXIS_Z; cx = ny; cy = -nx; cz = 0;
      end
      q = longint'(cx * cx + cy * cy + cz * cz);
      if (q == 0) begin
        cosc = COS_NONE;
        th = 1'b0;
      end else begin
        l = longint'(root_floor(q << 16));
        d = tx * cx + ty * cy + tz * cz;
        num = 255 * (d * 256 + l * s);
        den = 2 * l * s;
        bx = ny * cz - nz * cy;
        by = nz * cx - nx * cz;
        bz = nx * cy - ny * cx;
        e = tx * bx + ty * by + tz * bz;
        if (num <= 0) cosc = COS_MIN;
        else begin
          c = num / den;
          cosc = c > 255 ? COS_MAX : 8'(c);
        end
        th = 1'b0;
        if (e > 0) begin
          if (l >= ((longint'(1) << 62) >> (2 * FRAC - 8))) thr = longint'(1) << 62;
          else thr = l << (2 * FRAC - 8);
          if (e * 10000 > thr) th = 1'b1;
        end
      end
      return {flip, th, 2'(axis), cosc, code_y, code_x};
    endfunction

    function void note_vertex(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                              logic [15:0] tx, logic [15:0] ty, logic [15:0] tz,
                              logic flip);
      frames_due.push_back(encode_frame(nx, ny, nz, tx, ty, tz, flip));
      beats_in++;
    endfunction

    function void check_frame(logic [31:0] got);
      logic [31:0] want;
      beats_out++;
      if (frames_due.size() == 0) begin
        $error("unexpected frame %h", got);
        fails++;
        return;
      end
      want = frames_due.pop_front();
      if (got[9:0] !== want[9:0]) begin
        $error("normal x code: expected %0d actual %0d", want[9:0], got[9:0]); fails++;
      end
      if (got[19:10] !== want[19:10]) begin
        $error("normal y code: expected %0d actual %0d", want[19:10], got[19:10]); fails++;
      end
      if (got[27:20] !== want[27:20]) begin
        $error("cosine code: expected %0d actual %0d", want[27:20], got[27:20]); fails++;
      end
      if (got[29:28] !== want[29:28]) begin
        $error("axis: expected %0d actual %0d", want[29:28], got[29:28]); fails++;
      end
      if (got[30] !== want[30]) begin
        $error("tangent handedness: expected %0b actual %0b", want[30], got[30]); fails++;
      end
      if (got[31] !== want[31]) begin
        $error("binormal flip: expected %0b actual %0b", want[31], got[31]); fails++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  logic [15:0] in_normal_x, in_normal_y, in_normal_z;
  logic [15:0] in_tangent_x, in_tangent_y, in_tangent_z;
  logic in_binormal_flip;
  logic out_valid;
  logic [31:0] out_packed_frame;

  frame_scoreboard frames = new();
  int idle_pct;

  tangent_frame_encoder u_top (
    .clk, .rst_n, .start, .busy,
    .in_normal_x, .in_normal_y, .in_normal_z,
    .in_tangent_x, .in_tangent_y, .in_tangent_z,
    .in_binormal_flip, .out_valid, .out_packed_frame
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) frames.check_frame(out_packed_frame);
  end

  task automatic send_vertex(logic [15:0] nx, logic [15:0] ny, logic [15:0] nz,
                             logic [15:0] tx, logic [15:0] ty, logic [15:0] tz,
                             logic flip);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < idle_pct) @(posedge clk);
    end
    start <= 1'b1;
    in_normal_x <= nx; in_normal_y <= ny; in_normal_z <= nz;
    in_tangent_x <= tx; in_tangent_y <= ty; in_tangent_z <= tz;
    in_binormal_flip <= flip;
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    frames.note_vertex(nx, ny, nz, tx, ty, tz, flip);
  endtask

  function automatic logic [15:0] rand_comp(int mode);
    case (mode)
      0: return 16'($urandom);
      1: return 16'($signed($urandom_range(32)) - 16);
      default: return 16'($signed($urandom_range(32768)) - 16384);
    endcase
  endfunction

  task automatic send_random();
    logic [15:0] v[6];
    int mode;
    mode = $urandom_range(9);
    foreach (v[i]) v[i] = rand_comp(mode == 0 ? 0 : (mode == 1 ? 1 : 2));
    // sprinkle axis ties and normals parallel to an axis
    if ($urandom_range(9) == 0) v[4] = $urandom_range(1) ? v[3] : -v[3];
    if ($urandom_range(9) == 0) v[5] = v[4];
    if ($urandom_range(11) == 0) begin
      v[$urandom_range(2)] = 16'd0;
      v[$urandom_range(2)] = 16'd0;
    end
    send_vertex(v[0], v[1], v[2], v[3], v[4], v[5], 1'($urandom));
  endtask

  initial begin
    int wait_cycles;
    rst_n = 1'b0;
    start = 1'b0;
    in_normal_x = '0; in_normal_y = '0; in_normal_z = '0;
    in_tangent_x = '0; in_tangent_y = '0; in_tangent_z = '0;
    in_binormal_flip = 1'b0;
    idle_pct = 8;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero normal, zero tangent
    send_vertex(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 1'b0);
    send_vertex(16'd0, 16'd0, 16'd0, 16'd16384, 16'd0, 16'd0, 1'b1);
    // axis-aligned normals, both hemispheres
    send_vertex(16'd0, 16'd0, 16'd16384, 16'd16384, 16'd0, 16'd0, 1'b0);
    send_vertex(16'd0, 16'd0, -16'sd16384, 16'd0, 16'd16384, 16'd0, 1'b1);
    send_vertex(16'd16384, 16'd0, 16'd0, 16'd0, 16'd0, 16'd16384, 1'b0);
    send_vertex(-16'sd16384, 16'd0, 16'd0, 16'd0, -16'sd16384, 16'd0, 1'b1);
    send_vertex(16'd0, 16'd16384, 16'd0, 16'd0, 16'd0, -16'sd16384, 1'b0);
    send_vertex(16'd0, -16'sd16384, 16'd0, 16'd100, 16'd0, 16'd50, 1'b0);
    // normal parallel to the chosen axis gives a zero cross product
    send_vertex(16'd16384, 16'd0, 16'd0, 16'd16384, 16'd1, 16'd1, 1'b1);
    send_vertex(16'd0, 16'd0, 16'd9000, 16'd5, 16'd5, 16'd9000, 1'b0);
    // ties between tangent axes
    send_vertex(16'd9459, 16'd9459, 16'd9459, 16'd100, 16'd100, 16'd100, 1'b0);
    send_vertex(16'd3000, -16'sd5000, 16'd8000, 16'd2, -16'sd7, -16'sd7, 1'b1);
    send_vertex(16'd1, 16'd1, -16'sd1, -16'sd3, 16'd3, 16'd1, 1'b0);
    // lower hemisphere fold, all quadrants
    send_vertex(16'd5000, 16'd6000, -16'sd7000, 16'd4000, -16'sd100, 16'd9, 1'b1);
    send_vertex(-16'sd5000, 16'd6000, -16'sd7000, -16'sd4000, 16'd100, 16'd9, 1'b0);
    send_vertex(-16'sd5000, -16'sd6000, -16'sd7000, 16'd9, 16'd4000, 16'd1, 1'b1);
    send_vertex(16'd5000, -16'sd6000, -16'sd7000, 16'd9, 16'd1, -16'sd4000, 1'b0);
    // field extremes, out of range and saturating
    send_vertex(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 1'b1);
    send_vertex(16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 16'h7fff, 1'b1);
    send_vertex(16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff, 16'h8000, 1'b0);
    send_vertex(16'hffff, 16'h0001, 16'hffff, 16'h0001, 16'hffff, 16'h0000, 1'b1);
    send_vertex(16'd1, 16'd0, 16'd0, 16'd0, 16'd1, 16'd0, 1'b0);

    for (int i = 0; i < 930; i++) begin
      if (i == 310) idle_pct = 77;
      if (i == 620) idle_pct = 0;
      send_random();
    end
    start <= 1'b0;

    wait_cycles = 0;
    while (frames.frames_due.size() != 0 && wait_cycles < 1000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (50) @(posedge clk);
    if (frames.frames_due.size() != 0) begin
      $error("%0d frames never arrived", frames.frames_due.size());
      frames.fails++;
    end
    $display("%0d vertices sent, %0d frames checked, sender idle 8%%, 77%%, then none",
             frames.beats_in, frames.beats_out);
    if (frames.fails == 0) $display("tangent_frame_encoder_tb passed");
    else $display("tangent_frame_encoder_tb failed");
    $finish;
  end

  initial begin
    #200000;
    $display("tangent_frame_encoder_tb failed");
    $finish;
  end

endmodule
